// ===== rtl/time_of_day_string_parser_core_macros.svh =====
// Assertion macros shared by the time-of-day parser RTL.
// Users must provide clk_i and rst_ni in the including scope.
`ifndef TIME_OF_DAY_STRING_PARSER_CORE_MACROS_SVH
`define TIME_OF_DAY_STRING_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TODS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TODS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tods_pkg.sv =====
// Package for the time-of-day string parser: payload types, parse state,
// character constants and the per-byte parse step. No dependencies.
package tods_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
  } in_t;

  typedef struct packed {
    logic       valid_res;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       has_seconds;
  } out_t;

  typedef enum logic [4:0] {
    PH_HOURS   = 5'b00001,
    PH_MINUTES = 5'b00010,
    PH_SECONDS = 5'b00100,
    PH_OK      = 5'b01000,
    PH_FAIL    = 5'b10000
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [6:0] acc;
    logic       seen;
    logic [4:0] hrs;
    logic [5:0] mins;
    logic [5:0] secs;
    logic       secs_present;
  } parse_t;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [6:0] MaxHours  = 7'd23;
  localparam logic [6:0] MaxMinSec = 7'd59;
  localparam logic [9:0] AccSat    = 10'd99;

  localparam parse_t ParseReset = '{
    phase: PH_HOURS, acc: '0, seen: 1'b0, hrs: '0, mins: '0, secs: '0,
    secs_present: 1'b0
  };

  // Applies one byte to the parse state; a zero byte stands for the string end.
  function automatic parse_t take_byte(parse_t s, logic [7:0] c);
    parse_t     r;
    logic       dig;
    logic [7:0] d;
    logic [9:0] v;
    logic       part_ok;
    r       = s;
    dig     = c inside {[CharZero:CharNine]};
    d       = c - CharZero;
    v       = ({3'b000, s.acc} << 3) + ({3'b000, s.acc} << 1) + {2'b00, d};
    part_ok = 1'b0;
    if (s.phase == PH_OK || s.phase == PH_FAIL) begin
      r = s;
    end else if (dig) begin
      r.acc  = (v > AccSat) ? AccSat[6:0] : v[6:0];
      r.seen = 1'b1;
    end else begin
      case (s.phase)
        PH_HOURS: begin
          part_ok = s.seen && (s.acc <= MaxHours) && (c == CharColon);
          if (part_ok) begin
            r.hrs   = s.acc[4:0];
            r.phase = PH_MINUTES;
          end else begin
            r.phase = PH_FAIL;
          end
        end
        PH_MINUTES: begin
          part_ok = s.seen && (s.acc <= MaxMinSec);
          if (part_ok) begin
            r.mins  = s.acc[5:0];
            r.phase = (c == CharColon) ? PH_SECONDS : PH_OK;
          end else begin
            r.phase = PH_FAIL;
          end
        end
        default: begin
          part_ok = s.seen && (s.acc <= MaxMinSec);
          if (part_ok) begin
            r.secs         = s.acc[5:0];
            r.secs_present = 1'b1;
            r.phase        = PH_OK;
          end else begin
            r.phase = PH_FAIL;
          end
        end
      endcase
      r.acc  = '0;
      r.seen = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/tods_parse.sv =====
// Parse state register and per-byte update logic with result formation.
// Depends on tods_pkg.
module tods_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  tods_pkg::in_t      byte_i,
  output tods_pkg::out_t     res_o
);
  import tods_pkg::*;

  parse_t state_q, state_d;
  parse_t after_byte;
  parse_t after_end;
  logic   ok;

  always_comb begin
    after_byte = take_byte(state_q, byte_i.char_in);
    after_end  = take_byte(after_byte, CharNul);
    ok         = (after_end.phase == PH_OK);
    res_o.valid_res   = ok;
    res_o.hours       = ok ? after_end.hrs : '0;
    res_o.minutes     = ok ? after_end.mins : '0;
    res_o.seconds     = (ok && after_end.secs_present) ? after_end.secs : '0;
    res_o.has_seconds = ok && after_end.secs_present;
    state_d = state_q;
    if (fire_i) begin
      state_d = byte_i.last ? ParseReset : after_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ParseReset;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/time_of_day_string_parser_core.sv =====
// Top level of the time-of-day string parser: input register, parse unit,
// result register. Depends on tods_pkg, tods_parse and the macros header.
//
//   Channel | Direction | Handshake             | Payload
//   in      | input     | in_valid_i/in_ready_o | in_i  (char_in, last)
//   out     | output    | out_valid_o/out_ready_i | out_o (one result per string)
//
// One byte is accepted per cycle while no last byte is stalled; a result is registered when its last byte advances.
// The parse state update in tods_parse sets the rate: one byte per cycle while no last byte is stalled.
// Reset returns the parser to the hours field and empties both registers.
// A stalled output holds only bytes marked last; other bytes keep flowing.
`include "time_of_day_string_parser_core_macros.svh"

module time_of_day_string_parser_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tods_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tods_pkg::out_t out_o
);
  import tods_pkg::*;

  in_t  s1_q;
  logic s1_valid_q;
  out_t out_q;
  logic out_valid_q;
  out_t res;
  logic out_free;
  logic s1_adv;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_q.last || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  tods_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_adv),
    .byte_i (s1_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.last) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `TODS_ASSERT_IMP(a_invalid_zero, out_valid_o && !out_o.valid_res,
    out_o.hours == 5'd0 && out_o.minutes == 6'd0 && out_o.seconds == 6'd0
      && !out_o.has_seconds,
    "Invalid result carries nonzero fields.")
  `TODS_ASSERT_IMP(a_valid_range, out_valid_o && out_o.valid_res,
    out_o.hours <= 5'd23 && out_o.minutes <= 6'd59 && out_o.seconds <= 6'd59,
    "Valid result out of range.")
  `TODS_ASSERT_IMP(a_no_secs_zero, out_valid_o && !out_o.has_seconds,
    out_o.seconds == 6'd0, "Seconds set without a seconds part.")
  `TODS_ASSERT_IMP(a_hold_blocks, s1_valid_q && !s1_adv, !in_ready_o,
    "Input taken while the held byte is stalled.")
  `TODS_ASSERT_NXT(a_last_makes_result, s1_adv && s1_q.last, out_valid_q,
    "Last byte produced no result.")

endmodule
